FILE: rtl/cbc_pkg.sv
`default_nettype none

package cbc_pkg;

  // Default configuration, handed to the top level parameters.
  localparam int SLOT_BITS_DEF  = 14;
  localparam int MAX_OPS_DEF    = 32;
  localparam int MAX_LINES_DEF  = 8;
  localparam int LINE_WORDS_DEF = 4;

  // Port field widths.
  localparam int FUNC_W   = 2;
  localparam int REGION_W = 3;
  localparam int PADDR_W  = 32;
  localparam int INSTR_W  = 32;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 14;
  localparam int COUNT_W  = 6;
  localparam int INDEX_W  = 5;
  localparam int LINE_W   = 3;
  localparam int TOTAL_W  = 32;
  localparam int LIVE_W   = 15;

  // Cached address space: byte address, word address, page offset.
  localparam int ADDR_W = 23;
  localparam int WA_W   = ADDR_W - 2;
  localparam int PAGE_W = 12;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WORD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  localparam logic [REGION_W-1:0] REGION_UNCACHED = 3'd5;
  localparam logic [PADDR_W-1:0]  RAM_LIMIT       = 32'h0080_0000;

  // Classified commands passed from the front end to the back end.
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_BYPASS = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WORD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_IGNORE = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BYPASS  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HIT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MISS    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAKEN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLUSHED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd6;

  // Instruction fields that end a block.
  localparam logic [5:0] OPC_SPECIAL  = 6'h00;
  localparam logic [5:0] OPC_CLOSE_LO = 6'h01;
  localparam logic [5:0] OPC_CLOSE_HI = 6'h07;
  localparam logic [5:0] FN_JR        = 6'h08;
  localparam logic [5:0] FN_JALR      = 6'h09;
  localparam logic [5:0] FN_SYSCALL   = 6'h0C;
  localparam logic [5:0] FN_BREAK     = 6'h0D;

  // Depth of the command queue and of the result queue.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [WA_W-1:0]   quo;
    logic              closes;
  } cbc_cmd_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } cbc_stat_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] op_count;
    logic [INDEX_W-1:0] op_index;
    logic [LINE_W-1:0]  line_grp;
    logic               new_line;
    logic               last;
    logic [TOTAL_W-1:0] built_total;
    logic [TOTAL_W-1:0] displaced_total;
    logic [LIVE_W-1:0]  live_total;
  } cbc_res_t;

endpackage

`default_nettype wire

FILE: rtl/code_block_cache_builder.sv
// Direct-mapped cache of straight-line code blocks, tracked by tag and length.
// Requests enter through a queue port: push with the in_ fields while full is
// low. Each request gives exactly one result, read through a queue port: the
// oldest result sits on the out_ ports while empty is low and leaves on pop.
// A lookup request bypasses, hits, or starts a build in its slot; code-word
// requests then extend the block; flush empties every slot.
// A request passes the front queue, then the execute stage that holds the slot
// store read, then the result queue. Throughput is one request per cycle, set
// by the single read and single write port of the slot store, while no flush,
// clearing pass or full result queue holds it. A flush occupies the store for
// a clearing pass over all 2**SLOT_BITS slots (16384 by default) during which
// full stays high. After reset the same pass runs first; requests wait for it.
// When the receiver stops popping, two results wait in the result queue, the
// execute stage holds, and up to two more requests wait in the front queue
// before full rises.
`default_nettype none

module code_block_cache_builder #(
  parameter int SLOT_BITS  = cbc_pkg::SLOT_BITS_DEF,
  parameter int MAX_OPS    = cbc_pkg::MAX_OPS_DEF,
  parameter int MAX_LINES  = cbc_pkg::MAX_LINES_DEF,
  parameter int LINE_WORDS = cbc_pkg::LINE_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [cbc_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [cbc_pkg::REGION_W-1:0]  in_vaddr_region,
  input  wire logic [cbc_pkg::PADDR_W-1:0]   in_paddr,
  input  wire logic [cbc_pkg::INSTR_W-1:0]   in_instr,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [cbc_pkg::KIND_W-1:0]         out_kind,
  output logic [cbc_pkg::SLOT_W-1:0]         out_slot,
  output logic [cbc_pkg::COUNT_W-1:0]        out_op_count,
  output logic [cbc_pkg::INDEX_W-1:0]        out_op_index,
  output logic [cbc_pkg::LINE_W-1:0]         out_line_index,
  output logic                               out_new_line,
  output logic                               out_last,
  output logic [cbc_pkg::TOTAL_W-1:0]        out_built_total,
  output logic [cbc_pkg::TOTAL_W-1:0]        out_displaced_total,
  output logic [cbc_pkg::LIVE_W-1:0]         out_live_total
);

  logic               cmd_valid;
  cbc_pkg::cbc_cmd_t  cmd;
  cbc_pkg::cbc_stat_t stat;
  logic               res_space;
  logic               res_valid;
  cbc_pkg::cbc_res_t  res;
  cbc_pkg::cbc_res_t  head;

  // Front end: request queue and classification.
  cbc_front #(
    .LINE_WORDS (LINE_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .func      (in_func),
    .region    (in_vaddr_region),
    .paddr     (in_paddr),
    .instr     (in_instr),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Back end: slot store, build state and counters.
  cbc_back #(
    .SLOT_BITS  (SLOT_BITS),
    .MAX_OPS    (MAX_OPS),
    .MAX_LINES  (MAX_LINES),
    .LINE_WORDS (LINE_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (stat),
    .res_space (res_space),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue toward the receiver.
  cbc_out_q u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .space   (res_space),
    .empty   (empty),
    .pop     (pop),
    .rd_data (head)
  );

  assign out_kind            = head.kind;
  assign out_slot            = head.slot;
  assign out_op_count        = head.op_count;
  assign out_op_index        = head.op_index;
  assign out_line_index      = head.line_grp;
  assign out_new_line        = head.new_line;
  assign out_last            = head.last;
  assign out_built_total     = head.built_total;
  assign out_displaced_total = head.displaced_total;
  assign out_live_total      = head.live_total;

endmodule

`default_nettype wire

FILE: rtl/cbc_front.sv
`default_nettype none

module cbc_front #(
  parameter int LINE_WORDS = cbc_pkg::LINE_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [cbc_pkg::FUNC_W-1:0]     func,
  input  wire logic [cbc_pkg::REGION_W-1:0]   region,
  input  wire logic [cbc_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [cbc_pkg::INSTR_W-1:0]    instr,
  output logic                                cmd_valid,
  output cbc_pkg::cbc_cmd_t                   cmd,
  input  wire cbc_pkg::cbc_stat_t             stat
);

  localparam int DEPTH  = cbc_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = cbc_pkg::ADDR_W;
  localparam int WA_W   = cbc_pkg::WA_W;

  // Reciprocal of the line length; exact quotient for every word address.
  localparam int RECIP_SHIFT = WA_W + 5;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SHIFT) + 64'(LINE_WORDS) - 64'd1) / 64'(LINE_WORDS);
  localparam logic [RECIP_SHIFT:0] RECIP = RECIP_L[RECIP_SHIFT:0];
  localparam int PROD_W = WA_W + RECIP_SHIFT + 1;

  cbc_pkg::cbc_cmd_t  q_r [DEPTH];
  cbc_pkg::cbc_cmd_t  new_cmd;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PROD_W-1:0]  prod;
  logic               accept;

  // A branch, jump, syscall or break puts the next word in a delay slot.
  function automatic logic closes_block(input logic [cbc_pkg::INSTR_W-1:0] w);
    logic [5:0] op;
    logic [5:0] fn;
    op = w[31:26];
    fn = w[5:0];
    if (op >= cbc_pkg::OPC_CLOSE_LO && op <= cbc_pkg::OPC_CLOSE_HI) begin
      return 1'b1;
    end
    if (op == cbc_pkg::OPC_SPECIAL) begin
      return fn == cbc_pkg::FN_JR || fn == cbc_pkg::FN_JALR ||
             fn == cbc_pkg::FN_SYSCALL || fn == cbc_pkg::FN_BREAK;
    end
    return 1'b0;
  endfunction

  // Classify the request and precompute the line quotient of its address.
  always_comb begin
    prod           = PROD_W'(paddr[ADDR_W-1:2]) * PROD_W'(RECIP);
    new_cmd.addr   = paddr[ADDR_W-1:0];
    new_cmd.quo    = prod[RECIP_SHIFT +: WA_W];
    new_cmd.closes = closes_block(instr);
    case (func)
      cbc_pkg::FUNC_LOOKUP: begin
        if (region == cbc_pkg::REGION_UNCACHED || paddr >= cbc_pkg::RAM_LIMIT) begin
          new_cmd.cmd = cbc_pkg::CMD_BYPASS;
        end else begin
          new_cmd.cmd = cbc_pkg::CMD_LOOKUP;
        end
      end
      cbc_pkg::FUNC_WORD:  new_cmd.cmd = cbc_pkg::CMD_WORD;
      cbc_pkg::FUNC_FLUSH: new_cmd.cmd = cbc_pkg::CMD_FLUSH;
      default:             new_cmd.cmd = cbc_pkg::CMD_IGNORE;
    endcase
  end

  // The queue refuses requests while the slot store is being cleared.
  assign full      = (cnt_r == CNT_W'(DEPTH)) || stat.clearing;
  assign accept    = push && !full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (stat.take) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (accept && !stat.take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && stat.take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cbc_back.sv
`default_nettype none

module cbc_back #(
  parameter int SLOT_BITS  = cbc_pkg::SLOT_BITS_DEF,
  parameter int MAX_OPS    = cbc_pkg::MAX_OPS_DEF,
  parameter int MAX_LINES  = cbc_pkg::MAX_LINES_DEF,
  parameter int LINE_WORDS = cbc_pkg::LINE_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire cbc_pkg::cbc_cmd_t cmd,
  output cbc_pkg::cbc_stat_t     stat,
  input  wire logic              res_space,
  output logic                   res_valid,
  output cbc_pkg::cbc_res_t      res
);

  localparam int NSLOTS   = 1 << SLOT_BITS;
  localparam int LEN_W    = $clog2(MAX_OPS + 1);
  localparam int LINES_W  = $clog2(MAX_LINES + 1);
  localparam int OFF_W    = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int LIVEC_W  = SLOT_BITS + 1;
  localparam int ADDR_W   = cbc_pkg::ADDR_W;
  localparam int WA_W     = cbc_pkg::WA_W;
  localparam int PAGE_W   = cbc_pkg::PAGE_W;
  localparam int ENTRY_W  = ADDR_W + LEN_W;
  localparam int SLOT_W   = cbc_pkg::SLOT_W;
  localparam int COUNT_W  = cbc_pkg::COUNT_W;
  localparam int INDEX_W  = cbc_pkg::INDEX_W;
  localparam int LINE_W   = cbc_pkg::LINE_W;
  localparam int LIVE_W   = cbc_pkg::LIVE_W;
  localparam int TOTAL_W  = cbc_pkg::TOTAL_W;

  // Slot store: start address tag over block length, zero length is empty.
  logic [ENTRY_W-1:0]   slot_mem [NSLOTS];

  // Execute stage, loaded together with the slot store read.
  logic                 s1_valid_r;
  logic [cbc_pkg::CMD_W-1:0] s1_cmd_r;
  logic [ADDR_W-1:0]    s1_addr_r;
  logic                 s1_closes_r;
  logic [OFF_W-1:0]     s1_off_r;
  logic [ENTRY_W-1:0]   s1_rd_r;

  // Build state and counters.
  logic                 building_r, building_nxt;
  logic [SLOT_BITS-1:0] bslot_r, bslot_nxt;
  logic [ADDR_W-1:0]    baddr_r, baddr_nxt;
  logic [ADDR_W-1:0]    btag_r, btag_nxt;
  logic [LEN_W-1:0]     ops_r, ops_nxt;
  logic [LINES_W-1:0]   lines_r, lines_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic                 delay_r, delay_nxt;
  logic                 disp_flag_r, disp_flag_nxt;
  logic [TOTAL_W-1:0]   built_r, built_nxt;
  logic [TOTAL_W-1:0]   disp_r, disp_nxt;
  logic [LIVEC_W-1:0]   live_r, live_nxt;
  logic                 clear_r, clear_nxt;
  logic [SLOT_BITS-1:0] clear_idx_r, clear_idx_nxt;

  logic                 take;
  logic                 fire;
  logic [SLOT_BITS-1:0] rd_addr;
  logic [WA_W-1:0]      wa;
  logic [WA_W-1:0]      diff;
  logic [WA_W-1:0]      rem;
  logic [SLOT_BITS-1:0] s1_slot;
  logic [ADDR_W-1:0]    rd_tag;
  logic [LEN_W-1:0]     rd_len;
  logic                 nl;
  logic                 refuse;
  logic                 word_last;
  logic [LEN_W-1:0]     ops_inc;
  logic [LINES_W-1:0]   lines_inc;
  logic                 exec_we;
  logic [SLOT_BITS-1:0] exec_waddr;
  logic [ENTRY_W-1:0]   exec_wdata;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;

  // A request executes when the result queue has room.
  assign fire = s1_valid_r && res_space;

  // Take a new request when the execute stage is empty or firing, unless clearing or a flush is still in execute.
  assign take = cmd_valid && (!s1_valid_r || fire) && !clear_r &&
                !(s1_valid_r && s1_cmd_r == cbc_pkg::CMD_FLUSH);

  assign stat.take     = take;
  assign stat.clearing = clear_r;
  assign res_valid     = fire;

  // Word offset of the start address inside its line.
  always_comb begin
    wa   = cmd.addr[ADDR_W-1:2];
    diff = wa - WA_W'(cmd.quo * WA_W'(LINE_WORDS));
    rem  = (diff >= WA_W'(LINE_WORDS)) ? diff - WA_W'(LINE_WORDS) : diff;
  end

  assign rd_addr = cmd.addr[SLOT_BITS+1:2];
  assign s1_slot = s1_addr_r[SLOT_BITS+1:2];
  assign rd_tag  = s1_rd_r[ENTRY_W-1:LEN_W];
  assign rd_len  = s1_rd_r[LEN_W-1:0];

  // Execute the request held in the stage register.
  always_comb begin
    building_nxt  = building_r;
    bslot_nxt     = bslot_r;
    baddr_nxt     = baddr_r;
    btag_nxt      = btag_r;
    ops_nxt       = ops_r;
    lines_nxt     = lines_r;
    off_nxt       = off_r;
    delay_nxt     = delay_r;
    disp_flag_nxt = disp_flag_r;
    built_nxt     = built_r;
    disp_nxt      = disp_r;
    live_nxt      = live_r;
    clear_nxt     = clear_r;
    clear_idx_nxt = clear_idx_r;
    exec_we       = 1'b0;
    exec_waddr    = bslot_r;
    exec_wdata    = {btag_r, LEN_W'(0)};
    nl            = (ops_r == '0) || (off_r == '0);
    refuse        = ((ops_r != '0) && (baddr_r[PAGE_W-1:0] == '0)) ||
                    (nl && (lines_r >= LINES_W'(MAX_LINES)));
    ops_inc       = ops_r + 1'b1;
    lines_inc     = nl ? lines_r + 1'b1 : lines_r;
    word_last     = delay_r || (ops_inc >= LEN_W'(MAX_OPS));
    res           = '0;

    // Clearing pass walks one slot per cycle.
    if (clear_r) begin
      clear_idx_nxt = clear_idx_r + 1'b1;
      if (clear_idx_r == {SLOT_BITS{1'b1}}) begin
        clear_nxt = 1'b0;
      end
    end

    if (fire) begin
      case (s1_cmd_r)
        cbc_pkg::CMD_BYPASS: begin
          building_nxt = 1'b0;
          res.kind     = cbc_pkg::KIND_BYPASS;
        end
        cbc_pkg::CMD_LOOKUP: begin
          building_nxt = 1'b0;
          if (rd_len != '0 && rd_tag == s1_addr_r) begin
            res.kind     = cbc_pkg::KIND_HIT;
            res.slot     = SLOT_W'(s1_slot);
            res.op_count = COUNT_W'(rd_len);
            res.last     = 1'b1;
          end else begin
            // Miss: empty the slot and start building into it.
            disp_flag_nxt = (rd_len != '0);
            if (rd_len != '0) begin
              live_nxt = live_r - 1'b1;
            end
            exec_we      = 1'b1;
            exec_waddr   = s1_slot;
            exec_wdata   = {s1_addr_r, LEN_W'(0)};
            building_nxt = 1'b1;
            bslot_nxt    = s1_slot;
            baddr_nxt    = s1_addr_r;
            btag_nxt     = s1_addr_r;
            ops_nxt      = '0;
            lines_nxt    = '0;
            off_nxt      = s1_off_r;
            delay_nxt    = 1'b0;
            res.kind     = cbc_pkg::KIND_MISS;
            res.slot     = SLOT_W'(s1_slot);
          end
        end
        cbc_pkg::CMD_FLUSH: begin
          live_nxt      = '0;
          building_nxt  = 1'b0;
          clear_nxt     = 1'b1;
          clear_idx_nxt = '0;
          res.kind      = cbc_pkg::KIND_FLUSHED;
        end
        cbc_pkg::CMD_WORD: begin
          if (!building_r) begin
            res.kind = cbc_pkg::KIND_IGNORED;
          end else if (refuse) begin
            // Page crossing or line limit: close before this word.
            building_nxt = 1'b0;
            res.kind     = cbc_pkg::KIND_REFUSED;
            res.slot     = SLOT_W'(bslot_r);
            res.op_count = COUNT_W'(ops_r);
            res.last     = 1'b1;
          end else begin
            lines_nxt  = lines_inc;
            ops_nxt    = ops_inc;
            exec_we    = 1'b1;
            exec_waddr = bslot_r;
            exec_wdata = {btag_r, ops_inc};
            if (ops_r == '0) begin
              built_nxt = built_r + 1'b1;
              if (disp_flag_r) begin
                disp_nxt = disp_r + 1'b1;
              end
              live_nxt = live_r + 1'b1;
            end
            if (!word_last && s1_closes_r) begin
              delay_nxt = 1'b1;
            end
            baddr_nxt = baddr_r + ADDR_W'(4);
            off_nxt   = (off_r == OFF_W'(LINE_WORDS - 1)) ? '0 : off_r + 1'b1;
            if (word_last) begin
              building_nxt = 1'b0;
            end
            res.kind       = cbc_pkg::KIND_TAKEN;
            res.slot       = SLOT_W'(bslot_r);
            res.op_count   = word_last ? COUNT_W'(ops_inc) : '0;
            res.op_index   = INDEX_W'(ops_r);
            res.line_grp   = LINE_W'(lines_inc - 1'b1);
            res.new_line   = nl;
            res.last       = word_last;
          end
        end
        default: begin
          res.kind = cbc_pkg::KIND_IGNORED;
        end
      endcase
    end

    res.built_total     = built_nxt;
    res.displaced_total = disp_nxt;
    res.live_total      = LIVE_W'(live_nxt);
  end

  // Slot store write port: clearing pass or executed request.
  always_comb begin
    if (clear_r) begin
      mem_we    = 1'b1;
      mem_waddr = clear_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = exec_we;
      mem_waddr = exec_waddr;
      mem_wdata = exec_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Slot store read, with the write of the same edge forwarded.
  always_ff @(posedge clk) begin
    if (take) begin
      if (mem_we && mem_waddr == rd_addr) begin
        s1_rd_r <= mem_wdata;
      end else begin
        s1_rd_r <= slot_mem[rd_addr];
      end
      s1_cmd_r    <= cmd.cmd;
      s1_addr_r   <= cmd.addr;
      s1_closes_r <= cmd.closes;
      s1_off_r    <= rem[OFF_W-1:0];
    end
  end

  // Control state; reset starts a clearing pass over every slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      building_r  <= 1'b0;
      bslot_r     <= '0;
      baddr_r     <= '0;
      btag_r      <= '0;
      ops_r       <= '0;
      lines_r     <= '0;
      off_r       <= '0;
      delay_r     <= 1'b0;
      disp_flag_r <= 1'b0;
      built_r     <= '0;
      disp_r      <= '0;
      live_r      <= '0;
      clear_r     <= 1'b1;
      clear_idx_r <= '0;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      building_r  <= building_nxt;
      bslot_r     <= bslot_nxt;
      baddr_r     <= baddr_nxt;
      btag_r      <= btag_nxt;
      ops_r       <= ops_nxt;
      lines_r     <= lines_nxt;
      off_r       <= off_nxt;
      delay_r     <= delay_nxt;
      disp_flag_r <= disp_flag_nxt;
      built_r     <= built_nxt;
      disp_r      <= disp_nxt;
      live_r      <= live_nxt;
      clear_r     <= clear_nxt;
      clear_idx_r <= clear_idx_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cbc_out_q.sv
`default_nettype none

module cbc_out_q (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire cbc_pkg::cbc_res_t wr_data,
  output logic                   space,
  output logic                   empty,
  input  wire logic              pop,
  output cbc_pkg::cbc_res_t      rd_data
);

  localparam int DEPTH = cbc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbc_pkg::cbc_res_t q_r [DEPTH];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              do_pop;

  assign space   = (cnt_r != CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_pop  = pop && !empty;
  assign rd_data = q_r[rd_ptr_r];

  // Pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire
